// ----- src/mps_pkg.sv -----
// Shared types and constants for the multichannel pulse sequencer.
// Used by the sequencer core; depends on nothing else.
package mps_pkg;

  // Default channel table depth.
  localparam int DEF_MAX_CHANNELS = 16;

  // Results produced by one input word are capped at this count.
  localparam int RES_CAP = 16;
  localparam int RCW     = $clog2(RES_CAP + 1);

  // Pin numbers are seven bits wide.
  localparam int PIN_W  = 7;
  localparam int TIME_W = 32;

  // Result kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_LOAD_CHAN = 2'd1,
    CMD_LOAD_DFLT = 2'd2,
    CMD_ARM       = 2'd3
  } cmd_t;

  // Channel phase: steady level, or which edge comes next.
  typedef enum logic [1:0] {
    PH_STEADY    = 2'd0,
    PH_HIGH_NEXT = 2'd1,
    PH_LOW_NEXT  = 2'd2
  } phase_t;

  // Sequencer control states; each walk state is one pass over a table.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEADY,
    ST_TOGGLE,
    ST_RESTORE
  } state_t;

  // One channel table entry as stored in the channel RAM.
  typedef struct packed {
    logic [PIN_W-1:0]  pin;
    logic [TIME_W-1:0] on_dur;
    logic [TIME_W-1:0] off_dur;
    logic [TIME_W-1:0] next_time;
    phase_t            phase;
  } chan_entry_t;

  // One default table entry as stored in the default RAM.
  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             level;
  } dflt_entry_t;

endpackage

// ----- src/multichannel_pulse_sequencer_core.sv -----
// Multichannel pulse sequencer core: channel and default tables in RAM, walked
// by a read-modify-write pipeline. Depends on mps_pkg and mps_ram.
//
// A word is taken when start is high and busy is low. Load and arm words finish
// in the accepting cycle, and their single result, if any, is strobed on the next cycle.
// A tick word walks a table one entry per cycle through that table RAM's single
// read port, with the write-back of one entry overlapping the read of the next.
// Results appear on the result ports for exactly one cycle, marked by strobe,
// with last set on the final result of the word; the receiver cannot stall
// them and must take each one in the cycle it is shown. Table occupancy lives
// in flip-flop valid bits, so no clearing pass follows reset.
module multichannel_pulse_sequencer_core
  import mps_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  // Command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [3:0]          slot,
  input  logic [PIN_W-1:0]    pin_number,
  input  logic                idle_level,
  input  logic [TIME_W-1:0]   on_duration,
  input  logic [TIME_W-1:0]   off_duration,
  input  logic [TIME_W-1:0]   first_toggle,
  input  logic [TIME_W-1:0]   now_time,
  // Result channel
  output logic                strobe,
  output logic                kind,
  output logic [PIN_W-1:0]    out_pin,
  output logic                out_level,
  output logic                last,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNTW = $clog2(MAX_CHANNELS + 1);
  localparam int CHW  = $bits(chan_entry_t);
  localparam int DFW  = $bits(dflt_entry_t);

  // Configuration registers.
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;

  // Sequencer status.
  logic armed;
  logic running;
  logic defaults_loaded;
  logic [MAX_CHANNELS-1:0] chan_valid;
  logic [MAX_CHANNELS-1:0] dflt_valid;

  // Walk control.
  state_t            state;
  state_t            state_next;
  logic [CNTW-1:0]   idx;
  logic [IW-1:0]     ix;
  logic              in_range;
  logic              issue;
  logic              pass_end;
  logic              done;
  logic              p_vld;
  logic [IW-1:0]     p_idx;
  logic [TIME_W-1:0] now_q;
  logic              late_q;
  logic [RCW-1:0]    res_cnt;

  // Result held back one step so that last can be marked.
  logic              hold_vld;
  logic              hold_kind;
  logic [PIN_W-1:0]  hold_pin;
  logic              hold_level;

  // Word decode.
  logic              acc;
  logic              slot_ok;
  logic [IW-1:0]     slot_idx;
  logic              imm_vld;
  logic              imm_kind;
  logic [PIN_W-1:0]  imm_pin;
  logic              imm_level;
  logic              load_chan;
  logic              load_dflt;
  logic              arm_set;
  logic              seq_begin;

  // Evaluation of the entry read from RAM.
  chan_entry_t       rd_chan;
  dflt_entry_t       rd_dflt;
  logic [CHW-1:0]    chan_rdata;
  logic [DFW-1:0]    dflt_rdata;
  logic              produce;
  logic              produce_ok;
  logic [PIN_W-1:0]  prod_pin;
  logic              prod_level;
  logic              toggle_hit;
  chan_entry_t       wb_chan;
  chan_entry_t       ld_chan;
  dflt_entry_t       ld_dflt;

  // Channel RAM write port.
  logic              chan_we;
  logic [IW-1:0]     chan_waddr;
  logic [CHW-1:0]    chan_wdata;

  assign busy   = (state != ST_IDLE);
  assign acc    = start && !busy;
  assign pready = 1'b1;

  // Register reads by word address.
  assign prdata = paddr[2] ? end_time : start_time;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      end_time   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        end_time <= pwdata;
      end else begin
        start_time <= pwdata;
      end
    end
  end

  // Decode of load and arm words, which finish in the accepting cycle.
  always_comb begin
    slot_ok   = (32'(slot) < 32'(MAX_CHANNELS));
    slot_idx  = IW'(slot);
    imm_vld   = 1'b0;
    imm_kind  = KIND_WRITE;
    imm_pin   = '0;
    imm_level = 1'b0;
    load_chan = 1'b0;
    load_dflt = 1'b0;
    arm_set   = 1'b0;
    if (acc) begin
      unique case (cmd_t'(cmd))
        CMD_TICK: begin
        end
        CMD_LOAD_CHAN: begin
          if (armed || !slot_ok) begin
            imm_vld  = 1'b1;
            imm_kind = KIND_REJECT;
          end else begin
            load_chan = 1'b1;
          end
        end
        CMD_LOAD_DFLT: begin
          imm_vld = 1'b1;
          if (defaults_loaded || !slot_ok) begin
            imm_kind = KIND_REJECT;
          end else begin
            load_dflt = 1'b1;
            imm_pin   = pin_number;
            imm_level = idle_level;
          end
        end
        CMD_ARM: begin
          if (armed) begin
            imm_vld  = 1'b1;
            imm_kind = KIND_REJECT;
          end else begin
            arm_set = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry images written by the load words.
  always_comb begin
    ld_chan.pin       = pin_number;
    ld_chan.on_dur    = on_duration;
    ld_chan.off_dur   = off_duration;
    ld_chan.next_time = first_toggle;
    ld_chan.phase     = (on_duration != '0 && off_duration != '0) ? PH_HIGH_NEXT : PH_STEADY;
    ld_dflt.pin       = pin_number;
    ld_dflt.level     = idle_level;
  end

  // Read issue: one entry per cycle until the table ends or, in toggle and restore passes, an empty slot.
  assign ix       = idx[IW-1:0];
  assign in_range = (idx < CNTW'(MAX_CHANNELS));

  always_comb begin
    issue = 1'b0;
    unique case (state)
      ST_IDLE:    issue = 1'b0;
      ST_STEADY:  issue = in_range;
      ST_TOGGLE:  issue = in_range && chan_valid[ix];
      ST_RESTORE: issue = in_range && dflt_valid[ix];
      default:    issue = 1'b0;
    endcase
    pass_end = busy && !issue && !p_vld;
  end

  // Next state: a tick picks its first pass, and each pass ends on its own.
  always_comb begin
    state_next = state;
    seq_begin  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (acc && cmd_t'(cmd) == CMD_TICK && armed) begin
          if (!running) begin
            if (start_time <= now_time) begin
              state_next = ST_STEADY;
              seq_begin  = 1'b1;
            end
          end else if (now_time > end_time) begin
            state_next = ST_RESTORE;
          end else begin
            state_next = ST_TOGGLE;
          end
        end
      end
      ST_STEADY: begin
        if (pass_end) begin
          state_next = late_q ? ST_IDLE : ST_TOGGLE;
        end
      end
      ST_TOGGLE: begin
        if (pass_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESTORE: begin
        if (pass_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    done = pass_end && (state_next == ST_IDLE);
  end

  // Evaluate the entry that the RAM returns, and build its write-back.
  assign rd_chan = chan_entry_t'(chan_rdata);
  assign rd_dflt = dflt_entry_t'(dflt_rdata);

  always_comb begin
    produce    = 1'b0;
    prod_pin   = rd_chan.pin;
    prod_level = 1'b0;
    toggle_hit = 1'b0;
    wb_chan    = rd_chan;
    case (state)
      ST_STEADY: begin
        produce    = p_vld && (rd_chan.phase == PH_STEADY);
        prod_level = (rd_chan.on_dur != '0);
      end
      ST_TOGGLE: begin
        toggle_hit = p_vld && (rd_chan.phase != PH_STEADY) && (rd_chan.next_time <= now_q);
        produce    = toggle_hit;
        if (rd_chan.phase == PH_HIGH_NEXT) begin
          prod_level        = 1'b1;
          wb_chan.next_time = rd_chan.next_time + rd_chan.on_dur;
          wb_chan.phase     = PH_LOW_NEXT;
        end else begin
          prod_level        = 1'b0;
          wb_chan.next_time = rd_chan.next_time + rd_chan.off_dur;
          wb_chan.phase     = PH_HIGH_NEXT;
        end
      end
      ST_RESTORE: begin
        produce    = p_vld;
        prod_pin   = rd_dflt.pin;
        prod_level = rd_dflt.level;
      end
      default: begin
      end
    endcase
    produce_ok = produce && (res_cnt < RCW'(RES_CAP));
  end

  // Channel RAM write: loads while idle, toggle write-back while walking.
  always_comb begin
    if (toggle_hit) begin
      chan_we    = 1'b1;
      chan_waddr = p_idx;
      chan_wdata = CHW'(wb_chan);
    end else begin
      chan_we    = load_chan;
      chan_waddr = slot_idx;
      chan_wdata = CHW'(ld_chan);
    end
  end

  mps_ram #(
    .WIDTH (CHW),
    .DEPTH (MAX_CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (chan_waddr),
    .wdata (chan_wdata),
    .raddr (ix),
    .rdata (chan_rdata)
  );

  mps_ram #(
    .WIDTH (DFW),
    .DEPTH (MAX_CHANNELS)
  ) u_dflt_ram (
    .clk   (clk),
    .we    (load_dflt),
    .waddr (slot_idx),
    .wdata (DFW'(ld_dflt)),
    .raddr (ix),
    .rdata (dflt_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk counter, read pipeline flag and per-word captures.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      p_vld   <= 1'b0;
      res_cnt <= '0;
    end else begin
      p_vld <= issue && (state != ST_STEADY || chan_valid[ix]);
      if (acc) begin
        idx <= '0;
      end else if (pass_end) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
      if (acc) begin
        res_cnt <= '0;
      end else if (produce_ok) begin
        res_cnt <= res_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= ix;
    if (acc) begin
      now_q  <= now_time;
      late_q <= (now_time > end_time);
    end
  end

  // Sequence status and table occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      running         <= 1'b0;
      defaults_loaded <= 1'b0;
      chan_valid      <= '0;
      dflt_valid      <= '0;
    end else begin
      if (arm_set) begin
        armed           <= 1'b1;
        running         <= 1'b0;
        defaults_loaded <= 1'b1;
      end
      if (seq_begin) begin
        running <= 1'b1;
      end
      if (load_chan) begin
        chan_valid[slot_idx] <= 1'b1;
      end
      if (load_dflt) begin
        dflt_valid[slot_idx] <= 1'b1;
      end
      // Ending a sequence disarms and empties the channel table.
      if (done && state == ST_RESTORE) begin
        armed      <= 1'b0;
        running    <= 1'b0;
        chan_valid <= '0;
      end
    end
  end

  // Result output: each new result pushes the held one out; the end of a
  // word flushes the held one with last set.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      hold_vld <= 1'b0;
    end else begin
      strobe <= imm_vld || ((produce_ok || done) && hold_vld);
      if (produce_ok) begin
        hold_vld <= 1'b1;
      end else if (done) begin
        hold_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (imm_vld) begin
      kind      <= imm_kind;
      out_pin   <= imm_pin;
      out_level <= imm_level;
      last      <= 1'b1;
    end else if ((produce_ok || done) && hold_vld) begin
      kind      <= hold_kind;
      out_pin   <= hold_pin;
      out_level <= hold_level;
      last      <= done;
    end
    if (produce_ok) begin
      hold_kind  <= KIND_WRITE;
      hold_pin   <= prod_pin;
      hold_level <= prod_level;
    end
  end

  // A result is never left held once the block is idle again.
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !hold_vld)
    else $error("held result left over while idle");

  // A running sequence is always armed.
  a_running_armed: assert property (@(posedge clk) disable iff (rst)
    running |-> armed)
    else $error("running without armed");

  // Per-word result count stays within the cap.
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RCW'(RES_CAP))
    else $error("result count beyond cap");

  // Load and arm words never keep the block busy.
  a_cmd_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd != CMD_TICK) |=> !busy)
    else $error("load or arm word left block busy");

endmodule

// ----- src/mps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the channel and default tables; depends on nothing else.
module mps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  raddr,
  rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
